[rtl/cli_pkg.sv]
// Shared constants, codes and the item type of the CAN channel LED indicator.
`default_nettype none

package cli_pkg;

   // Defaults of the top-level parameters
   localparam int unsigned CHANNELS_DEFAULT         = 4;
   localparam int unsigned BLINK_MS_DEFAULT         = 100;
   localparam int unsigned BREATH_PERIOD_MS_DEFAULT = 800;

   // Field widths
   localparam int MODE_W   = 2;
   localparam int CHAN_W   = 2;
   localparam int TICK_W   = 32;
   localparam int MASK_W   = 4;
   localparam int HOLD_W   = 16;
   localparam int BRIGHT_W = 8;

   localparam logic [HOLD_W-1:0]   HOLD_RESET = 16'd220;
   localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 8'hFF;

   // Item modes
   localparam logic [MODE_W-1:0] MODE_ACTIVITY = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REFRESH  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [CHAN_W-1:0] chan;
      logic [TICK_W-1:0] tick;
      logic [MASK_W-1:0] en;
      logic [MASK_W-1:0] bo;
   } item_type;

endpackage

`default_nettype wire

[rtl/can_channel_led_indicator.sv]
// Top level of the CAN channel status LED indicator.
//  - req_ channel: one beat per firmware event. mode 0 marks traffic on
//    req_channel, mode 1 refreshes all LEDs at time req_tick_ms, mode 2
//    clears the LED state, mode 3 is a no-op. Every beat yields one rsp_ beat.
//  - rsp_ channel: logical LED mask, active-low pin levels and the mask of
//    pins that were driven (only on a refresh, where the state changed or was unknown).
//  - csr_ port: activity hold time in ms, written whenever csr_write_enable
//    is high; only change it while no beat is in flight.
//  - A new beat is taken every cycle unless the receiver stalls: five register
//    stages (two reciprocal-multiply stages for the blink and breath periods,
//    the phase and ramp stage, the brightness multiply, the per-channel state
//    stage that loads the result register).
//  - All LED state lives in the last stage, so beats update it strictly in
//    order and back-to-back beats see each other's effects.
//  - When the receiver stalls, each stage holds and stages fill up behind it;
//    req_ready drops only once every stage is full. With rsp_valid low,
//    req_ready is always high.
//  - Reset empties the pipeline, zeros expiry ticks and accumulators, marks
//    every cached LED state unknown (next refresh drives every pin) and loads
//    the hold time with 220 ms.
`default_nettype none

module can_channel_led_indicator #(
   parameter int unsigned CHANNELS         = cli_pkg::CHANNELS_DEFAULT,
   parameter int unsigned BLINK_MS         = cli_pkg::BLINK_MS_DEFAULT,
   parameter int unsigned BREATH_PERIOD_MS = cli_pkg::BREATH_PERIOD_MS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [cli_pkg::MODE_W-1:0]  req_mode,
   input  wire logic [cli_pkg::CHAN_W-1:0]  req_channel,
   input  wire logic [cli_pkg::TICK_W-1:0]  req_tick_ms,
   input  wire logic [cli_pkg::MASK_W-1:0]  req_enabled_mask,
   input  wire logic [cli_pkg::MASK_W-1:0]  req_busoff_mask,
   // response channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [cli_pkg::MASK_W-1:0]       rsp_led_on_mask,
   output logic [cli_pkg::MASK_W-1:0]       rsp_pin_level_mask,
   output logic [cli_pkg::MASK_W-1:0]       rsp_written_mask,
   // configuration
   input  wire logic                        csr_write_enable,
   input  wire logic [cli_pkg::HOLD_W-1:0]  csr_write_data
);

   localparam int TICK_W   = cli_pkg::TICK_W;
   localparam int MASK_W   = cli_pkg::MASK_W;
   localparam int BRIGHT_W = cli_pkg::BRIGHT_W;

   // Exact division of a TICK_W-bit value by a constant: q = (x * M) >> (TICK_W + L)
   // with L = ceil(log2 d), M = ceil(2^(TICK_W+L) / d), M has TICK_W+1 bits.
   // M is split in two halves so each multiplier stays within 32 bits.
   localparam int RECIP_W = TICK_W + 1;
   localparam int SPLIT   = 16;
   localparam int PH_W    = TICK_W + RECIP_W - SPLIT;
   localparam int PL_W    = TICK_W + SPLIT;
   localparam int PROD_W  = TICK_W + RECIP_W;

   localparam int BLINK_L  = $clog2(BLINK_MS);
   localparam logic [63:0] BLINK_RECIP =
      ((64'd1 << (TICK_W + BLINK_L)) + 64'(BLINK_MS) - 64'd1) / 64'(BLINK_MS);
   localparam logic [RECIP_W-SPLIT-1:0] BLINK_M_HI = BLINK_RECIP[RECIP_W-1:SPLIT];
   localparam logic [SPLIT-1:0]         BLINK_M_LO = BLINK_RECIP[SPLIT-1:0];

   localparam int BREATH_L = $clog2(BREATH_PERIOD_MS);
   localparam logic [63:0] BREATH_RECIP =
      ((64'd1 << (TICK_W + BREATH_L)) + 64'(BREATH_PERIOD_MS) - 64'd1)
      / 64'(BREATH_PERIOD_MS);
   localparam logic [RECIP_W-SPLIT-1:0] BREATH_M_HI = BREATH_RECIP[RECIP_W-1:SPLIT];
   localparam logic [SPLIT-1:0]         BREATH_M_LO = BREATH_RECIP[SPLIT-1:0];

   // Phase within the breath period and the 0..255 ramp
   localparam int PW        = $clog2(BREATH_PERIOD_MS + 1);
   localparam int TW        = PW + BRIGHT_W;
   localparam int HALF      = BREATH_PERIOD_MS / 2;
   localparam int HALF_L    = $clog2(HALF);
   localparam logic [63:0] HALF_RECIP =
      ((64'd1 << (TW + HALF_L)) + 64'(HALF) - 64'd1) / 64'(HALF);
   localparam logic [TW:0]   HALF_M    = HALF_RECIP[TW:0];
   localparam int            MD_W      = 2 * TW + 1;
   localparam logic [PW-1:0] PERIOD_PW = PW'(BREATH_PERIOD_MS);
   localparam logic [PW-1:0] HALF_PW   = PW'(HALF);

   // ---------------------------------------------------------------------
   // Handshake: each stage moves when the one after it can take the beat.
   // ---------------------------------------------------------------------
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, rsp_valid_ff;
   logic a_valid_in, b_valid_in, c_valid_in, d_valid_in, rsp_valid_in;
   logic a_ready, b_ready, c_ready, d_ready, e_ready;
   logic d_fire;

   assign e_ready   = !rsp_valid_ff || rsp_ready;
   assign d_ready   = !d_valid_ff || e_ready;
   assign c_ready   = !c_valid_ff || d_ready;
   assign b_ready   = !b_valid_ff || c_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign req_ready = a_ready;
   assign d_fire    = d_valid_ff && e_ready;

   assign a_valid_in   = a_ready ? req_valid  : a_valid_ff;
   assign b_valid_in   = b_ready ? a_valid_ff : b_valid_ff;
   assign c_valid_in   = c_ready ? b_valid_ff : c_valid_ff;
   assign d_valid_in   = d_ready ? c_valid_ff : d_valid_ff;
   assign rsp_valid_in = e_ready ? d_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
         d_valid_ff   <= d_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage A: register the beat and the reciprocal partial products.
   // ---------------------------------------------------------------------
   cli_pkg::item_type req_item;
   cli_pkg::item_type a_item_ff, b_item_ff, c_item_ff, d_item_ff;

   assign req_item.mode = req_mode;
   assign req_item.chan = req_channel;
   assign req_item.tick = req_tick_ms;
   assign req_item.en   = req_enabled_mask;
   assign req_item.bo   = req_busoff_mask;

   logic [PH_W-1:0] a_blink_hi_ff, a_breath_hi_ff;
   logic [PL_W-1:0] a_blink_lo_ff, a_breath_lo_ff;

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_item_ff      <= req_item;
         a_blink_hi_ff  <= PH_W'(req_tick_ms) * PH_W'(BLINK_M_HI);
         a_blink_lo_ff  <= PL_W'(req_tick_ms) * PL_W'(BLINK_M_LO);
         a_breath_hi_ff <= PH_W'(req_tick_ms) * PH_W'(BREATH_M_HI);
         a_breath_lo_ff <= PL_W'(req_tick_ms) * PL_W'(BREATH_M_LO);
      end
   end

   // ---------------------------------------------------------------------
   // Stage B: combine partial products -> blink parity, breath quotient.
   // ---------------------------------------------------------------------
   logic [PROD_W-1:0] blink_prod, breath_prod;
   logic              b_blink_odd_ff;
   logic [PW-1:0]     b_breath_q_ff;

   assign blink_prod  = {a_blink_hi_ff, {SPLIT{1'b0}}} + PROD_W'(a_blink_lo_ff);
   assign breath_prod = {a_breath_hi_ff, {SPLIT{1'b0}}} + PROD_W'(a_breath_lo_ff);

   always_ff @(posedge clock) begin
      if (b_ready) begin
         b_item_ff      <= a_item_ff;
         b_blink_odd_ff <= blink_prod[TICK_W + BLINK_L];
         // only the low bits of the quotient matter for the remainder
         b_breath_q_ff  <= breath_prod[TICK_W + BREATH_L +: PW];
      end
   end

   // ---------------------------------------------------------------------
   // Stage C: phase = tick mod period, triangle ramp times 255.
   // ---------------------------------------------------------------------
   logic [PW-1:0] phase, ramp;
   logic [TW-1:0] ramp_scaled;
   logic          c_blink_odd_ff;
   logic [TW-1:0] c_num_ff;

   // phase < period < 2^PW, so PW-bit arithmetic is exact
   assign phase       = b_item_ff.tick[PW-1:0] - b_breath_q_ff * PERIOD_PW;
   assign ramp        = (phase < HALF_PW) ? phase : PERIOD_PW - phase;
   assign ramp_scaled = {ramp, {BRIGHT_W{1'b0}}} - TW'(ramp);

   always_ff @(posedge clock) begin
      if (c_ready) begin
         c_item_ff      <= b_item_ff;
         c_blink_odd_ff <= b_blink_odd_ff;
         c_num_ff       <= ramp_scaled;
      end
   end

   // ---------------------------------------------------------------------
   // Stage D: brightness = num / half, saturated at full scale.
   // ---------------------------------------------------------------------
   logic [MD_W-1:0]     half_prod, half_q;
   logic [BRIGHT_W-1:0] bright;
   logic                d_blink_odd_ff;
   logic [BRIGHT_W-1:0] d_bright_ff;

   assign half_prod = MD_W'(c_num_ff) * MD_W'(HALF_M);
   assign half_q    = half_prod >> (TW + HALF_L);
   assign bright    = (half_q > MD_W'(cli_pkg::BRIGHT_MAX)) ? cli_pkg::BRIGHT_MAX
                                                            : half_q[BRIGHT_W-1:0];

   always_ff @(posedge clock) begin
      if (d_ready) begin
         d_item_ff      <= c_item_ff;
         d_blink_odd_ff <= c_blink_odd_ff;
         d_bright_ff    <= bright;
      end
   end

   // ---------------------------------------------------------------------
   // Stage E: per-channel state and the result register.
   // ---------------------------------------------------------------------
   logic [cli_pkg::HOLD_W-1:0] hold_ff;
   logic [TICK_W-1:0]          expiry_ff [CHANNELS];
   logic [TICK_W-1:0]          expiry_in [CHANNELS];
   logic [BRIGHT_W-1:0]        acc_ff    [CHANNELS];
   logic [BRIGHT_W-1:0]        acc_in    [CHANNELS];
   logic [CHANNELS-1:0]        known_ff, known_in, on_ff, on_in;

   logic [TICK_W-1:0]          diff_ch [CHANNELS];
   logic [BRIGHT_W:0]          sum_ch  [CHANNELS];
   logic [CHANNELS-1:0]        en_ch, bo_ch, active_ch, breathe_ch, want_ch;
   logic [MASK_W+CHANNELS-1:0] en_wide, bo_wide, lit_wide, written_wide;
   logic [CHANNELS-1:0]        written_ch, lit_ch;

   // channels beyond the mask width read as disabled
   assign en_wide = {{CHANNELS{1'b0}}, d_item_ff.en};
   assign bo_wide = {{CHANNELS{1'b0}}, d_item_ff.bo};
   assign en_ch   = en_wide[CHANNELS-1:0];
   assign bo_ch   = bo_wide[CHANNELS-1:0];

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         // active when expiry is 1 .. 2^31-1 ahead (wrap-safe)
         diff_ch[i]    = expiry_ff[i] - d_item_ff.tick;
         active_ch[i]  = (|diff_ch[i]) && !diff_ch[i][TICK_W-1];
         sum_ch[i]     = {1'b0, d_bright_ff} + {1'b0, acc_ff[i]};
         breathe_ch[i] = en_ch[i] && !bo_ch[i] && !active_ch[i];
         if (!en_ch[i]) begin
            want_ch[i] = 1'b0;
         end else if (bo_ch[i]) begin
            want_ch[i] = 1'b1;
         end else if (active_ch[i]) begin
            want_ch[i] = !d_blink_odd_ff;
         end else begin
            want_ch[i] = sum_ch[i][BRIGHT_W];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         expiry_in[i] = expiry_ff[i];
         acc_in[i]    = acc_ff[i];
      end
      known_in   = known_ff;
      on_in      = on_ff;
      written_ch = '0;
      if (d_fire) begin
         case (d_item_ff.mode)
            cli_pkg::MODE_ACTIVITY: begin
               for (int i = 0; i < CHANNELS; i++) begin
                  if (32'(d_item_ff.chan) == i) begin
                     expiry_in[i] = d_item_ff.tick + TICK_W'(hold_ff);
                  end
               end
            end
            cli_pkg::MODE_REFRESH: begin
               for (int i = 0; i < CHANNELS; i++) begin
                  if (!en_ch[i]) begin
                     acc_in[i] = '0;
                  end else if (breathe_ch[i]) begin
                     acc_in[i] = sum_ch[i][BRIGHT_W-1:0];
                  end
                  // drive the pin only on a change or from unknown
                  if (!known_ff[i] || (on_ff[i] != want_ch[i])) begin
                     known_in[i]   = 1'b1;
                     on_in[i]      = want_ch[i];
                     written_ch[i] = 1'b1;
                  end
               end
            end
            cli_pkg::MODE_CLEAR: begin
               for (int i = 0; i < CHANNELS; i++) begin
                  expiry_in[i] = '0;
                  acc_in[i]    = '0;
               end
               known_in = '0;
               on_in    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign lit_ch       = known_in & on_in;
   assign lit_wide     = {{MASK_W{1'b0}}, lit_ch};
   assign written_wide = {{MASK_W{1'b0}}, written_ch};

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff  <= cli_pkg::HOLD_RESET;
         known_ff <= '0;
         on_ff    <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            expiry_ff[i] <= '0;
            acc_ff[i]    <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            hold_ff <= csr_write_data;
         end
         known_ff <= known_in;
         on_ff    <= on_in;
         for (int i = 0; i < CHANNELS; i++) begin
            expiry_ff[i] <= expiry_in[i];
            acc_ff[i]    <= acc_in[i];
         end
      end
   end

   logic [MASK_W-1:0] rsp_lit_ff, rsp_written_ff;

   always_ff @(posedge clock) begin
      if (d_fire) begin
         rsp_lit_ff     <= lit_wide[MASK_W-1:0];
         rsp_written_ff <= written_wide[MASK_W-1:0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_led_on_mask    = rsp_lit_ff;
   assign rsp_pin_level_mask = ~rsp_lit_ff;
   assign rsp_written_mask   = rsp_written_ff;

endmodule

`default_nettype wire

[rtl/cli_checker.sv]
// Port-level checks for the CAN channel LED indicator, bound to the top level.
`default_nettype none

module cli_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [cli_pkg::MASK_W-1:0] rsp_led_on_mask,
   input wire logic [cli_pkg::MASK_W-1:0] rsp_pin_level_mask,
   input wire logic [cli_pkg::MASK_W-1:0] rsp_written_mask
);

   // pins are the active-low image of the logical mask
   pin_polarity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pin_level_mask == ~rsp_led_on_mask))
      else $error("pin levels do not mirror LED mask");

   // an empty result register means the whole pipe can move
   ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low while no result is pending");

   // reset leaves no result behind
   empty_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // stalled result beat holds
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_led_on_mask)
                                 && $stable(rsp_written_mask))
      else $error("stalled result beat changed");

endmodule

bind can_channel_led_indicator cli_checker u_cli_checker (.*);

`default_nettype wire

[tb/sv/tb_cli_scoreboard_pkg.sv]
// Scoreboard class with its own LED predictor for the CAN channel LED indicator bench.
package tb_cli_scoreboard_pkg;

   import cli_pkg::*;

   // Mode with no effect on the block
   localparam logic [MODE_W-1:0] MODE_IDLE = 2'd3;

   // Reports past this many mismatches are counted only
   localparam int unsigned REPORT_LIMIT = 10;

   typedef enum logic [1:0] {LED_OFF, LED_ON, LED_UNKNOWN} led_cache_type;

   typedef struct packed {
      logic [MASK_W-1:0] lit;
      logic [MASK_W-1:0] pins;
      logic [MASK_W-1:0] written;
   } led_view_type;

   class led_scoreboard;
      logic [TICK_W-1:0] expiry_at [CHANNELS_DEFAULT];
      int unsigned       duty_acc  [CHANNELS_DEFAULT];
      led_cache_type     led_cache [CHANNELS_DEFAULT];
      logic [HOLD_W-1:0] hold_ms;
      led_view_type      views_due [$];
      int unsigned       failures;

      function new();
         hold_ms  = HOLD_RESET;
         failures = 0;
         clear_leds();
      endfunction

      function void clear_leds();
         for (int ch = 0; ch < CHANNELS_DEFAULT; ch++) begin
            expiry_at[ch] = '0;
            duty_acc[ch]  = 0;
            led_cache[ch] = LED_UNKNOWN;
         end
      endfunction

      function void set_hold(logic [HOLD_W-1:0] value);
         hold_ms = value;
      endfunction

      function int unsigned pending();
         return views_due.size();
      endfunction

      // Apply one accepted beat and queue the LED view it must produce.
      function void note_request(item_type beat);
         led_view_type      view;
         logic [TICK_W-1:0] gap;
         int unsigned       phase;
         int unsigned       level;
         logic              lit_now;
         led_cache_type     want;

         view = '0;
         case (beat.mode)
            MODE_ACTIVITY: expiry_at[beat.chan] = beat.tick + {16'd0, hold_ms};
            MODE_CLEAR:    clear_leds();
            MODE_REFRESH: begin
               for (int ch = 0; ch < CHANNELS_DEFAULT; ch++) begin
                  gap = expiry_at[ch] - beat.tick;
                  if (!beat.en[ch]) begin
                     lit_now      = 1'b0;
                     duty_acc[ch] = 0;
                  end else if (beat.bo[ch]) begin
                     lit_now = 1'b1;
                  end else if (gap != '0 && !gap[TICK_W-1]) begin
                     lit_now = ((beat.tick / BLINK_MS_DEFAULT) % 2) == 0;
                  end else begin
                     // triangle brightness into a modulo-256 density accumulator
                     phase = beat.tick % BREATH_PERIOD_MS_DEFAULT;
                     if (phase < BREATH_PERIOD_MS_DEFAULT / 2)
                        level = (phase * 255) / (BREATH_PERIOD_MS_DEFAULT / 2);
                     else
                        level = ((BREATH_PERIOD_MS_DEFAULT - phase) * 255)
                                / (BREATH_PERIOD_MS_DEFAULT / 2);
                     if (level > 255)
                        level = 255;
                     level = level + duty_acc[ch];
                     lit_now = level >= 256;
                     duty_acc[ch] = lit_now ? level - 256 : level;
                  end
                  want = lit_now ? LED_ON : LED_OFF;
                  if (led_cache[ch] != want) begin
                     led_cache[ch]    = want;
                     view.written[ch] = 1'b1;
                  end
               end
            end
            default: ;
         endcase

         for (int ch = 0; ch < CHANNELS_DEFAULT; ch++)
            view.lit[ch] = led_cache[ch] == LED_ON;
         view.pins = ~view.lit;
         views_due.push_back(view);
      endfunction

      function void check_response(led_view_type seen);
         led_view_type due;

         if (views_due.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("ERROR: response beat with none due: lit %h pins %h written %h",
                        seen.lit, seen.pins, seen.written);
            return;
         end
         due = views_due.pop_front();
         if (due != seen) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display({"ERROR: lit exp %h got %h, pins exp %h got %h, ",
                         "written exp %h got %h"},
                        due.lit, seen.lit, due.pins, seen.pins,
                        due.written, seen.written);
         end
      endfunction

      function bit passed();
         return failures == 0 && views_due.size() == 0;
      endfunction
   endclass

endpackage

[tb/sv/tb_can_channel_led_indicator.sv]
// Top-level bench: directed and paced random beats into the LED indicator, every response checked.
module tb_can_channel_led_indicator;
   timeunit 1ns;
   timeprecision 1ps;

   import cli_pkg::*;
   import tb_cli_scoreboard_pkg::*;

   // About 1900 beats plus drains and the hold-off; the limit leaves a wide
   // margin on top of that.
   localparam int unsigned CYCLE_LIMIT    = 200_000;
   localparam int unsigned SEGMENTS       = 6;
   localparam int unsigned SEGMENT_BEATS  = 312;
   localparam int unsigned HOLDOFF_CYCLES = 150;
   // five pipeline stages plus slack
   localparam int unsigned SETTLE_CYCLES  = 10;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode         = '0;
   logic [CHAN_W-1:0]   req_channel      = '0;
   logic [TICK_W-1:0]   req_tick_ms      = '0;
   logic [MASK_W-1:0]   req_enabled_mask = '0;
   logic [MASK_W-1:0]   req_busoff_mask  = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [MASK_W-1:0]   rsp_led_on_mask;
   logic [MASK_W-1:0]   rsp_pin_level_mask;
   logic [MASK_W-1:0]   rsp_written_mask;
   logic                csr_write_enable = 1'b0;
   logic [HOLD_W-1:0]   csr_write_data   = '0;

   // Pacing knobs, percent of cycles idle; written by the stimulus only
   int unsigned send_idle_pct    = 17;
   int unsigned recv_idle_pct    = 67;
   // Stimulus bumps this to ask the receiver for one long hold-off
   int unsigned holdoff_requests = 0;
   // Receiver-private bookkeeping
   int unsigned holdoff_taken    = 0;
   int unsigned holdoff_left     = 0;
   int unsigned cycle_count      = 0;

   led_scoreboard led_board;

   can_channel_led_indicator i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_channel        (req_channel),
      .req_tick_ms        (req_tick_ms),
      .req_enabled_mask   (req_enabled_mask),
      .req_busoff_mask    (req_busoff_mask),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_led_on_mask    (rsp_led_on_mask),
      .rsp_pin_level_mask (rsp_pin_level_mask),
      .rsp_written_mask   (rsp_written_mask),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver: random back-pressure, plus one long hold-off on request.
   // The hold-off is counted here so the sender keeps offering beats meanwhile,
   // which fills every stage and drops req_ready.
   always @(posedge clock) begin
      if (holdoff_left != 0) begin
         holdoff_left = holdoff_left - 1;
         rsp_ready <= 1'b0;
      end else if (holdoff_taken != holdoff_requests) begin
         holdoff_taken = holdoff_requests;
         holdoff_left  = HOLDOFF_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: values read here are the ones present at the edge, since all
   // drivers (bench and block) update through nonblocking assignments.
   always @(posedge clock) begin
      item_type     beat_in;
      led_view_type beat_out;
      if (!reset) begin
         if (req_valid && req_ready) begin
            beat_in = {req_mode, req_channel, req_tick_ms, req_enabled_mask,
                       req_busoff_mask};
            led_board.note_request(beat_in);
         end
         if (rsp_valid && rsp_ready) begin
            beat_out = {rsp_led_on_mask, rsp_pin_level_mask, rsp_written_mask};
            led_board.check_response(beat_out);
         end
      end
   end

   // Offer one beat, with a random gap first, and return at the edge that
   // takes it. Valid stays high across back-to-back beats.
   task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [CHAN_W-1:0] chan,
                            input logic [TICK_W-1:0] tick, input logic [MASK_W-1:0] en,
                            input logic [MASK_W-1:0] bo);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_channel      <= chan;
      req_tick_ms      <= tick;
      req_enabled_mask <= en;
      req_busoff_mask  <= bo;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering and wait until every due response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (led_board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Hold-time write; only called while the pipeline is empty.
   task automatic write_hold(input logic [HOLD_W-1:0] value);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      led_board.set_hold(value);
   endtask

   initial begin
      logic [TICK_W-1:0] now_ms;
      logic [HOLD_W-1:0] hold_pick;
      logic [MODE_W-1:0] mode_pick;
      logic [MASK_W-1:0] en_pick;
      logic [MASK_W-1:0] bo_pick;
      int unsigned       roll;

      led_board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part, hold time still at its reset value of 220 ms ----
      // unknown cache: first refresh drives every pin, even to off
      send_beat(MODE_REFRESH, 2'd0, 32'd0, 4'h0, 4'h0);
      // bus-off lights all, then a repeat writes nothing
      send_beat(MODE_REFRESH, 2'd0, 32'd0, 4'hF, 4'hF);
      send_beat(MODE_REFRESH, 2'd0, 32'd0, 4'hF, 4'hF);
      // traffic on every channel, expiry at 1220
      for (int ch = 0; ch < CHANNELS_DEFAULT; ch++)
         send_beat(MODE_ACTIVITY, CHAN_W'(ch), 32'd1000, 4'hF, 4'h0);
      // blink: even period on, odd period off
      send_beat(MODE_REFRESH, 2'd0, 32'd1050, 4'hF, 4'h0);
      send_beat(MODE_REFRESH, 2'd0, 32'd1150, 4'hF, 4'h0);
      // tick equal to expiry is no longer active, so it breathes
      send_beat(MODE_REFRESH, 2'd0, 32'd1220, 4'hF, 4'h0);
      // breath peak: brightness reaches 255 at half period
      send_beat(MODE_REFRESH, 2'd0, 32'd2000, 4'hF, 4'h0);
      // tick at its top, mixed masks
      send_beat(MODE_REFRESH, 2'd3, 32'hFFFF_FFFF, 4'h5, 4'hA);
      // mode three does nothing
      send_beat(MODE_IDLE, 2'd2, 32'h1234_5678, 4'hF, 4'hF);
      // clear, then refresh forces every pin again
      send_beat(MODE_CLEAR, 2'd1, 32'd77, 4'hF, 4'hF);
      send_beat(MODE_REFRESH, 2'd0, 32'd200, 4'hF, 4'h0);
      // expiry wrapping past zero stays active
      send_beat(MODE_ACTIVITY, 2'd2, 32'hFFFF_FFF0, 4'h0, 4'h0);
      send_beat(MODE_REFRESH, 2'd0, 32'h0000_0010, 4'h4, 4'h0);
      // difference of exactly half the range is inactive, one less is active
      send_beat(MODE_ACTIVITY, 2'd3, 32'h0000_1000, 4'h0, 4'h0);
      send_beat(MODE_REFRESH, 2'd0, 32'h8000_10DC, 4'h8, 4'h0);
      send_beat(MODE_REFRESH, 2'd0, 32'h8000_10DD, 4'h8, 4'h0);
      // clear keeps the hold time: active one tick before expiry, not at it
      send_beat(MODE_CLEAR, 2'd0, 32'd0, 4'h0, 4'h0);
      send_beat(MODE_ACTIVITY, 2'd0, 32'd5000, 4'h0, 4'h0);
      send_beat(MODE_REFRESH, 2'd0, 32'd5219, 4'h1, 4'h0);
      send_beat(MODE_REFRESH, 2'd0, 32'd5220, 4'h1, 4'h0);
      drain_responses();

      // ---- random part: segments with different hold times and pacing ----
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0:       hold_pick = 16'd1;
            1:       hold_pick = 16'hFFFF;
            3:       hold_pick = HOLD_RESET;
            default: hold_pick = HOLD_W'($urandom_range(2, 2000));
         endcase
         // sender light / receiver heavy, then swapped, then no idling
         case (seg / 2)
            0: begin
               send_idle_pct = 17;
               recv_idle_pct = 67;
            end
            1: begin
               send_idle_pct = 67;
               recv_idle_pct = 17;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         write_hold(hold_pick);

         // odd segments start just below the wrap of the tick counter
         if (seg % 2 == 1)
            now_ms = 32'hFFFF_F000 + TICK_W'($urandom_range(0, 32'hFFF));
         else
            now_ms = $urandom;

         for (int n = 0; n < SEGMENT_BEATS; n++) begin
            if (seg == 1 && n == 100)
               holdoff_requests++;
            if (seg == 3 && n == 150)
               drain_responses();

            roll = $urandom_range(99);
            if (roll < 8) begin
               // noise: any field value, any mode
               send_beat(MODE_W'($urandom), CHAN_W'($urandom), $urandom,
                         MASK_W'($urandom), MASK_W'($urandom));
            end else begin
               // firmware-like traffic: time moves forward, mostly in small steps
               roll = $urandom_range(99);
               if (roll < 3)
                  now_ms = now_ms + $urandom;
               else if (roll < 15)
                  now_ms = now_ms + $urandom_range(600);
               else
                  now_ms = now_ms + $urandom_range(30);

               roll = $urandom_range(99);
               if (roll < 45)
                  mode_pick = MODE_ACTIVITY;
               else if (roll < 95)
                  mode_pick = MODE_REFRESH;
               else if (roll < 98)
                  mode_pick = MODE_CLEAR;
               else
                  mode_pick = MODE_IDLE;

               en_pick = ($urandom_range(1) == 0) ? '1 : MASK_W'($urandom);
               bo_pick = ($urandom_range(3) == 0) ? MASK_W'($urandom) : '0;
               send_beat(mode_pick, CHAN_W'($urandom), now_ms, en_pick, bo_pick);
            end
         end
         drain_responses();
      end

      if (led_board.passed())
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[files.f]
rtl/cli_pkg.sv
rtl/can_channel_led_indicator.sv
rtl/cli_checker.sv
tb/sv/tb_cli_scoreboard_pkg.sv
tb/sv/tb_can_channel_led_indicator.sv
